[src/rpv_pkg.sv]
// Package for the regular polygon vertex generator: payload structs,
// register indexes, default parameters and the CORDIC arctangent table.
// No dependencies.
`default_nettype none
package rpv_pkg;
  localparam int DEF_MAX_SIDES  = 64;
  localparam int DEF_PHASE_BITS = 24;
  localparam int CORDIC_STEPS   = 24;
  localparam logic signed [32:0] CORDIC_ONE = 33'sd652032874;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;

  typedef struct packed {
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic [6:0]         side_count;
  } in_t;

  typedef struct packed {
    logic [5:0]         vertex_index;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               last_vertex;
  } out_t;

  function automatic logic signed [32:0] atan_at(input logic [4:0] i);
    case (i)
      5'd0:  atan_at = 33'sd536870912;
      5'd1:  atan_at = 33'sd316933406;
      5'd2:  atan_at = 33'sd167458907;
      5'd3:  atan_at = 33'sd85004756;
      5'd4:  atan_at = 33'sd42667331;
      5'd5:  atan_at = 33'sd21354465;
      5'd6:  atan_at = 33'sd10679838;
      5'd7:  atan_at = 33'sd5340245;
      5'd8:  atan_at = 33'sd2670163;
      5'd9:  atan_at = 33'sd1335087;
      5'd10: atan_at = 33'sd667544;
      5'd11: atan_at = 33'sd333772;
      5'd12: atan_at = 33'sd166886;
      5'd13: atan_at = 33'sd83443;
      5'd14: atan_at = 33'sd41722;
      5'd15: atan_at = 33'sd20861;
      5'd16: atan_at = 33'sd10430;
      5'd17: atan_at = 33'sd5215;
      5'd18: atan_at = 33'sd2608;
      5'd19: atan_at = 33'sd1304;
      5'd20: atan_at = 33'sd652;
      5'd21: atan_at = 33'sd326;
      5'd22: atan_at = 33'sd163;
      5'd23: atan_at = 33'sd81;
      default: atan_at = 33'sd0;
    endcase
  endfunction
endpackage
`default_nettype wire

[src/regular_polygon_vertex_generator.sv]
// Regular polygon vertex generator, top level. Uses rpv_pkg, rpv_div, rpv_cordic.
// The first vertex transaction follows the input transaction once the phase-step divider
// is done; each further vertex then needs a 24-step CORDIC rotation and the products
// on the shared 33x18 multiplier. One request at a time.
// Synchronous active-high reset clears the center registers and the sequencer.
`default_nettype none
module regular_polygon_vertex_generator #(
  parameter int MAX_SIDES  = rpv_pkg::DEF_MAX_SIDES,
  parameter int PHASE_BITS = rpv_pkg::DEF_PHASE_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire rpv_pkg::in_t in_item,
  output logic              out_valid,
  input  wire logic         out_stall,
  output rpv_pkg::out_t     out_item,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import rpv_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_EMIT = 3'd2,
                         S_COR = 3'd3, S_MUL = 3'd4, S_FIN = 3'd5;

  logic [2:0]              state;
  logic signed [31:0]      cx, cy;
  logic [6:0]              n, k;
  logic signed [32:0]      dxr, dyr;
  logic [PHASE_BITS-1:0]   step, phase;
  logic                    div_start, div_done, cor_start, cor_done;
  logic [PHASE_BITS-1:0]   div_q;
  logic signed [17:0]      cq, sq, cr, sr;
  logic [2:0]              mcnt;
  logic signed [32:0]      ma;
  logic signed [17:0]      mb;
  logic signed [50:0]      p;
  logic signed [51:0]      acc, sx, sy_now;
  logic [6:0]              n_clamp;

  function automatic logic signed [31:0] fin_coord(input logic signed [31:0] ctr,
                                                   input logic signed [51:0] v);
    logic signed [51:0] r;
    logic signed [36:0] t;
    r = v + 52'sd32768;
    t = 37'(ctr) + 37'($signed(r[51:16]));
    if (t > 37'sd2147483647) fin_coord = 32'sh7FFF_FFFF;
    else if (t < -37'sd2147483648) fin_coord = 32'sh8000_0000;
    else fin_coord = t[31:0];
  endfunction

  always_comb begin
    if (in_item.side_count < 7'd3) n_clamp = 7'd3;
    else if (in_item.side_count > 7'(MAX_SIDES)) n_clamp = 7'(MAX_SIDES);
    else n_clamp = in_item.side_count;
  end

  always_comb begin
    case (mcnt)
      3'd0:    begin ma = dxr; mb = cr; end
      3'd1:    begin ma = dyr; mb = sr; end
      3'd2:    begin ma = dxr; mb = sr; end
      default: begin ma = dyr; mb = cr; end
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign div_start = in_valid && !in_stall;
  assign cor_start = (state == S_EMIT) && out_valid && !out_stall && !out_item.last_vertex;
  assign sy_now    = acc + 52'(p);

  rpv_div #(.PHASE_BITS(PHASE_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .divisor(n_clamp),
    .done(div_done), .quot(div_q)
  );

  rpv_cordic #(.PHASE_BITS(PHASE_BITS)) u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .phase(phase),
    .done(cor_done), .cos_q(cq), .sin_q(sq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cx        <= '0;
      cy        <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_CENTER_X) cx <= cfg_data;
      if (cfg_we && cfg_index == REG_CENTER_Y) cy <= cfg_data;
      case (state)
        S_IDLE: begin
          if (div_start) begin
            n     <= n_clamp;
            dxr   <= 33'(in_item.ref_x) - 33'(cx);
            dyr   <= 33'(in_item.ref_y) - 33'(cy);
            out_item.vertex_x <= in_item.ref_x;
            out_item.vertex_y <= in_item.ref_y;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            step  <= div_q;
            phase <= div_q;
            k     <= 7'd1;
            out_item.vertex_index <= 6'd0;
            out_item.last_vertex  <= 1'b0;
            out_valid <= 1'b1;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
            state <= out_item.last_vertex ? S_IDLE : S_COR;
          end
        end
        S_COR: begin
          if (cor_done) begin
            cr    <= cq;
            sr    <= sq;
            mcnt  <= 3'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          p    <= ma * mb;
          mcnt <= mcnt + 3'd1;
          case (mcnt)
            3'd1:    acc <= 52'(p);
            3'd2:    sx  <= acc - 52'(p);
            3'd3:    acc <= 52'(p);
            default: acc <= acc;
          endcase
          if (mcnt == 3'd4) state <= S_FIN;
        end
        S_FIN: begin
          out_item.vertex_x     <= fin_coord(cx, sx);
          out_item.vertex_y     <= fin_coord(cy, sy_now);
          out_item.vertex_index <= k[5:0];
          out_item.last_vertex  <= (k == n - 7'd1);
          out_valid <= 1'b1;
          k     <= k + 7'd1;
          phase <= phase + step;
          state <= S_EMIT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/rpv_div.sv]
// Restoring divider, one quotient bit per cycle: step = round(2^PHASE_BITS / n).
// Depends on rpv_pkg.
`default_nettype none
module rpv_div #(
  parameter int PHASE_BITS = rpv_pkg::DEF_PHASE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [6:0]            divisor,
  output logic                       done,
  output logic [PHASE_BITS-1:0]      quot
);
  import rpv_pkg::*;
  localparam int NW = PHASE_BITS + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num;
  logic [NW-1:0] q;
  logic [7:0]    rem;
  logic [6:0]    d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [7:0]    trial;

  assign trial = {rem[6:0], num[NW-1]};
  assign quot  = q[PHASE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        d    <= divisor;
        rem  <= 8'd0;
        q    <= '0;
        num  <= (NW'(1) << PHASE_BITS) + NW'(divisor >> 1);
      end else if (busy) begin
        num <= num << 1;
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[src/rpv_cordic.sv]
// Iterative CORDIC, one micro-rotation per cycle, giving Q1.16 cos and sin
// of a phase. Depends on rpv_pkg.
`default_nettype none
module rpv_cordic #(
  parameter int PHASE_BITS = rpv_pkg::DEF_PHASE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [PHASE_BITS-1:0]  phase,
  output logic                        done,
  output logic signed [17:0]          cos_q,
  output logic signed [17:0]          sin_q
);
  import rpv_pkg::*;
  localparam int SH = 32 - PHASE_BITS;

  logic [31:0]        p32;
  logic [31:0]        pq;
  logic signed [32:0] x, y, z;
  logic [1:0]         quad;
  logic [4:0]         cnt;
  logic               busy, fin;
  logic signed [33:0] c, s;

  function automatic logic signed [17:0] rnd(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd8192) >>> 14;
    if (r > 34'sd65536) rnd = 18'sd65536;
    else if (r < -34'sd65536) rnd = -18'sd65536;
    else rnd = r[17:0];
  endfunction

  assign p32 = 32'(phase) << SH;
  assign pq  = p32 + 32'h2000_0000;

  always_comb begin
    case (quad)
      2'd0:    begin c = 34'(x);  s = 34'(y);  end
      2'd1:    begin c = -34'(y); s = 34'(x);  end
      2'd2:    begin c = -34'(x); s = -34'(y); end
      default: begin c = 34'(y);  s = -34'(x); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        quad <= pq[31:30];
        x    <= CORDIC_ONE;
        y    <= '0;
        z    <= 33'(signed'(p32 - {pq[31:30], 30'd0}));
      end else if (busy) begin
        if (!z[32]) begin
          x <= x - (y >>> cnt);
          y <= y + (x >>> cnt);
          z <= z - atan_at(cnt);
        end else begin
          x <= x + (y >>> cnt);
          y <= y - (x >>> cnt);
          z <= z + atan_at(cnt);
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin   <= 1'b0;
        done  <= 1'b1;
        cos_q <= rnd(c);
        sin_q <= rnd(s);
      end
    end
  end
endmodule
`default_nettype wire

[sim/tb_regular_polygon_vertex_generator.sv]
// Testbench for regular_polygon_vertex_generator: drives reference vertices and
// center settings, predicts every vertex with an in-bench CORDIC rotation and
// checks each output transaction in order. Depends on rpv_pkg and the top level.
module tb_regular_polygon_vertex_generator;
  import rpv_pkg::*;

  localparam logic [1:0] REG_UNUSED_A = 2'd2;
  localparam logic [1:0] REG_UNUSED_B = 2'd3;
  localparam int SIDES_MAX  = 64;
  localparam int DRAIN_WAIT = 60;
  localparam int STALL_LIMIT = 20000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_t         in_item;
  logic        out_valid;
  logic        out_stall;
  out_t        out_item;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  out_t   vertex_queue[$];
  longint center_x_model;
  longint center_y_model;
  int     mismatches;
  int     sender_idle_pct;
  int     receiver_stall_pct;
  int     quiet_cycles;

  regular_polygon_vertex_generator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void cordic_sin_cos(input logic [23:0] phase,
                                         output longint c, output longint s);
    longint p32, q, z, x, y, dx, dy, rc, rs;
    p32 = longint'({phase, 8'd0});
    q = ((p32 + (64'sd1 <<< 29)) >>> 30) & 3;
    z = p32 - (q <<< 30);
    x = 652032874;
    y = 0;
    if (z >= (64'sd1 <<< 31)) z -= (64'sd1 <<< 32);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_at(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_at(5'(i)));
      end
    end
    case (q)
      0: begin rc = x;  rs = y;  end
      1: begin rc = -y; rs = x;  end
      2: begin rc = -x; rs = -y; end
      default: begin rc = y; rs = -x; end
    endcase
    c = (rc + 8192) >>> 14;
    s = (rs + 8192) >>> 14;
    if (c > 65536) c = 65536;
    if (c < -65536) c = -65536;
    if (s > 65536) s = 65536;
    if (s < -65536) s = -65536;
  endfunction

  function automatic longint saturate32(input longint v);
    return (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
  endfunction

  function automatic void predict_polygon(input in_t req);
    longint n, phase_step, dxr, dyr, c, s;
    out_t   v;
    n = req.side_count;
    if (n < 3) n = 3;
    if (n > SIDES_MAX) n = SIDES_MAX;
    phase_step = ((64'sd1 <<< 24) + n / 2) / n;
    dxr = longint'(req.ref_x) - center_x_model;
    dyr = longint'(req.ref_y) - center_y_model;
    for (longint k = 0; k < n; k++) begin
      v.vertex_index = 6'(k);
      v.last_vertex  = (k == n - 1);
      if (k == 0) begin
        v.vertex_x = req.ref_x;
        v.vertex_y = req.ref_y;
      end else begin
        cordic_sin_cos(24'(k * phase_step), c, s);
        v.vertex_x = 32'(saturate32(center_x_model + ((dxr * c - dyr * s + 32768) >>> 16)));
        v.vertex_y = 32'(saturate32(center_y_model + ((dxr * s + dyr * c + 32768) >>> 16)));
      end
      vertex_queue.push_back(v);
    end
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (vertex_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected vertex idx=%0d x=%0d y=%0d last=%0b", out_item.vertex_index,
                   out_item.vertex_x, out_item.vertex_y, out_item.last_vertex);
      end else begin
        want = vertex_queue.pop_front();
        if (out_item.vertex_index !== want.vertex_index || out_item.vertex_x !== want.vertex_x ||
            out_item.vertex_y !== want.vertex_y || out_item.last_vertex !== want.last_vertex) begin
          mismatches++;
          if (mismatches <= 10)
            $display("vertex mismatch: exp i=%0d x=%0d y=%0d l=%0b got i=%0d x=%0d y=%0d l=%0b",
                     want.vertex_index, want.vertex_x, want.vertex_y, want.last_vertex,
                     out_item.vertex_index, out_item.vertex_x, out_item.vertex_y,
                     out_item.last_vertex);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid is left high after a transaction when no gap follows
  task automatic send_request(input in_t req);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
    predict_polygon(req);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CENTER_X) center_x_model = longint'(signed'(data));
    else if (idx == REG_CENTER_Y) center_y_model = longint'(signed'(data));
    @(posedge clk);
  endtask

  function automatic in_t make_request(input logic [31:0] x, input logic [31:0] y,
                                       input logic [6:0] n);
    in_t r;
    r.ref_x = x;
    r.ref_y = y;
    r.side_count = n;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord;
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return 32'($signed($urandom_range(131071)) - 65536);
      default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(255)
                                        : 32'h8000_0000 + $urandom_range(255);
    endcase
  endfunction

  function automatic logic [6:0] rand_sides;
    int r;
    r = $urandom_range(99);
    if (r < 80) return 7'($urandom_range(12, 3));
    if (r < 90) return 7'($urandom_range(64, 13));
    return 7'($urandom_range(127));
  endfunction

  task automatic test_basic_shapes;
    send_request(make_request(32'h0001_0000, 32'h0000_0000, 7'd4));
    send_request(make_request(32'h0000_0000, 32'h0000_0000, 7'd3));
    send_request(make_request(32'h0005_0000, 32'hFFFD_0000, 7'd6));
    send_request(make_request(32'h0001_0000, 32'h0001_0000, 7'd64));
    drain();
  endtask

  task automatic test_side_count_limits;
    send_request(make_request(32'h0002_0000, 32'h0000_0000, 7'd0));
    send_request(make_request(32'h0002_0000, 32'h0000_0000, 7'd1));
    send_request(make_request(32'h0002_0000, 32'h0000_0000, 7'd2));
    send_request(make_request(32'h0002_0000, 32'h0000_0000, 7'd65));
    send_request(make_request(32'h0002_0000, 32'h0000_0000, 7'd127));
    drain();
  endtask

  task automatic test_coordinate_extremes;
    send_request(make_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd4));
    send_request(make_request(32'h8000_0000, 32'h8000_0000, 7'd4));
    send_request(make_request(32'h7FFF_FFFF, 32'h8000_0000, 7'd5));
    drain();
    write_reg(REG_CENTER_X, 32'h8000_0000);
    write_reg(REG_CENTER_Y, 32'h7FFF_FFFF);
    send_request(make_request(32'h7FFF_FFFF, 32'h8000_0000, 7'd8));
    send_request(make_request(32'h0000_0000, 32'h0000_0000, 7'd3));
    drain();
    write_reg(REG_CENTER_X, 32'h7FFF_FFFF);
    write_reg(REG_CENTER_Y, 32'h8000_0000);
    send_request(make_request(32'h8000_0000, 32'h7FFF_FFFF, 7'd7));
    send_request(make_request(32'hFFFF_FFFF, 32'h0000_0001, 7'd4));
    drain();
  endtask

  task automatic test_ignored_register;
    write_reg(REG_CENTER_X, 32'h0003_0000);
    write_reg(REG_CENTER_Y, 32'hFFFE_8000);
    write_reg(REG_UNUSED_A, 32'h1234_5678);
    write_reg(REG_UNUSED_B, 32'hDEAD_BEEF);
    send_request(make_request(32'h0008_0000, 32'h0001_0000, 7'd5));
    drain();
  endtask

  task automatic test_random_polygons(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 39) begin
        drain();
        write_reg($urandom_range(1) ? REG_CENTER_X : REG_CENTER_Y, rand_coord());
      end
      send_request(make_request(rand_coord(), rand_coord(), rand_sides()));
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_CENTER_X;
    cfg_data = '0;
    mismatches = 0;
    quiet_cycles = 0;
    center_x_model = 0;
    center_y_model = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_shapes();
    test_side_count_limits();
    test_coordinate_extremes();
    test_ignored_register();

    sender_idle_pct = 25;
    receiver_stall_pct = 76;
    test_random_polygons(70);
    sender_idle_pct = 76;
    receiver_stall_pct = 25;
    test_random_polygons(70);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    write_reg(REG_CENTER_X, 32'h0000_0000);
    write_reg(REG_CENTER_Y, 32'h0000_0000);
    test_random_polygons(70);

    if (vertex_queue.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
